// ----- design/successor_take_engine_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Successor take engine assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off by rst_ni.
// ----------------------------------------------------------------------------
`ifndef SUCCESSOR_TAKE_ENGINE_UNIT_MACROS_SVH
`define SUCCESSOR_TAKE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define STE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ste_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Successor take engine package
// Shared widths, command types and back end states.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int ValW          = 10;
  localparam int ValSpan       = 1 << ValW;
  localparam int WordW         = 32;
  localparam int BitW          = 5;
  localparam int FifoDepth     = 2;
  localparam int FifoPtrW      = 1;
  localparam int DefValueRange = 1024;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_NOSUCC
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ValW-1:0]   pos;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } back_state_e;

endpackage

// ----- design/successor_take_engine_unit.sv -----
`timescale 1ns / 1ps
// Load: accepted into the command queue, then read, set and written back by the back end; no result.
// Query: result valid once the back end has scanned the 32-bit bitmap words, one
// per cycle (1 to 32 at the default range), or with no scan if no successor can exist.
// Back end: one command at a time, held further by output stalls; two more may wait queued.
// Reset: asynchronous, active low; per-word valid flops empty the set at once.
// ----------------------------------------------------------------------------
// Successor take engine
// Set of values with load and successor-take queries, front end and back end
// decoupled by a two-entry command queue.
// ----------------------------------------------------------------------------
module successor_take_engine_unit import ste_pkg::*; #(
  parameter int VALUE_RANGE = DefValueRange
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            in_mode_i,
  input  logic [ValW-1:0] in_value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [ValW-1:0] out_taken_value_o,
  output logic            out_found_o
);

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  ste_front #(
    .VALUE_RANGE(VALUE_RANGE)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_mode_i  (in_mode_i),
    .in_value_i (in_value_i),
    .fifo_full_i(full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ste_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .full_o (full),
    .empty_o(empty)
  );

  ste_back #(
    .VALUE_RANGE(VALUE_RANGE)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (head_cmd),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_taken_value_o(out_taken_value_o),
    .out_found_o      (out_found_o)
  );

endmodule

// ----- design/ste_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Successor take engine front end
// Turns inputs into load, query or no-successor commands; out-of-range loads are dropped.
// ----------------------------------------------------------------------------
module ste_front import ste_pkg::*; #(
  parameter int VALUE_RANGE = DefValueRange
) (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            in_mode_i,
  input  logic [ValW-1:0] in_value_i,
  input  logic            fifo_full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  localparam int EffRange = (VALUE_RANGE < ValSpan) ? VALUE_RANGE : ValSpan;

  logic [ValW:0] start;
  logic          keep;

  assign in_stall_o = fifo_full_i;
  assign start      = {1'b0, in_value_i} + (ValW+1)'(1);

  always_comb begin
    keep        = 1'b1;
    cmd_o.kind  = CMD_LOAD;
    cmd_o.pos   = in_value_i;
    if (in_mode_i) begin
      cmd_o.pos = start[ValW-1:0];
      if (start >= (ValW+1)'(EffRange)) begin
        cmd_o.kind = CMD_NOSUCC;
      end else begin
        cmd_o.kind = CMD_QUERY;
      end
    end else if ({1'b0, in_value_i} >= (ValW+1)'(EffRange)) begin
      keep = 1'b0;
    end
  end

  assign push_o = in_valid_i && !fifo_full_i && keep;

endmodule

// ----- design/ste_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Successor take engine command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ste_fifo import ste_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                entries_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + FifoPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + FifoPtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (FifoPtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (FifoPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/ste_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Successor take engine back end
// Holds the presence bitmap and executes loads and word-by-word successor scans.
// ----------------------------------------------------------------------------
module ste_back import ste_pkg::*; #(
  parameter int VALUE_RANGE = DefValueRange
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [ValW-1:0] out_taken_value_o,
  output logic            out_found_o
);

  localparam int EffRange = (VALUE_RANGE < ValSpan) ? VALUE_RANGE : ValSpan;
  localparam int Words    = (EffRange + WordW - 1) / WordW;
  localparam int AddrW    = (Words > 1) ? $clog2(Words) : 1;

  function automatic logic [BitW-1:0] lowest_set(logic [WordW-1:0] w);
    logic [BitW-1:0] pos;
    pos = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BitW'(i);
      end
    end
    return pos;
  endfunction

  logic [WordW-1:0] mem_q [Words];
  logic [Words-1:0] vld_q;

  back_state_e      state_q, state_d;
  cmd_kind_e        kind_q, kind_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             first_q, first_d;
  logic [ValW-1:0]  taken_q, taken_d;
  logic             found_q, found_d;
  logic [WordW-1:0] rd_data_q;
  logic             rd_vld_q;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [WordW-1:0] wr_data;
  logic [WordW-1:0] word;
  logic [WordW-1:0] bits;
  logic [BitW-1:0]  low;
  logic [AddrW+BitW-1:0] hit_pos;

  assign word    = rd_vld_q ? rd_data_q : '0;
  assign bits    = word & (first_q ? ({WordW{1'b1}} << bit_q) : {WordW{1'b1}});
  assign low     = lowest_set(bits);
  assign hit_pos = {addr_q, low};

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    bit_d   = bit_q;
    addr_d  = addr_q;
    first_d = first_q;
    taken_d = taken_q;
    found_d = found_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = addr_q;
    wr_en   = 1'b0;
    wr_data = word;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          kind_d = cmd_i.kind;
          bit_d  = cmd_i.pos[BitW-1:0];
          case (cmd_i.kind)
            CMD_LOAD, CMD_QUERY: begin
              rd_en   = 1'b1;
              rd_addr = AddrW'(cmd_i.pos >> BitW);
              addr_d  = rd_addr;
              first_d = 1'b1;
              state_d = ST_SCAN;
            end
            default: begin
              taken_d = '0;
              found_d = 1'b0;
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (kind_q == CMD_LOAD) begin
          wr_en   = 1'b1;
          wr_data = word | ({{(WordW-1){1'b0}}, 1'b1} << bit_q);
          state_d = ST_IDLE;
        end else if (bits != '0) begin
          wr_en   = 1'b1;
          wr_data = word & ~({{(WordW-1){1'b0}}, 1'b1} << low);
          taken_d = ValW'(hit_pos);
          found_d = 1'b1;
          state_d = ST_OUT;
        end else if (addr_q == AddrW'(Words - 1)) begin
          taken_d = '0;
          found_d = 1'b0;
          state_d = ST_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = addr_q + AddrW'(1);
          addr_d  = rd_addr;
          first_d = 1'b0;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    bit_q   <= bit_d;
    addr_q  <= addr_d;
    first_q <= first_d;
    taken_q <= taken_d;
    found_q <= found_d;
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[addr_q] <= wr_data;
    end
  end

  assign out_valid_o       = (state_q == ST_OUT);
  assign out_taken_value_o = taken_q;
  assign out_found_o       = found_q;

endmodule

// ----- design/ste_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Successor take engine checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "successor_take_engine_unit_macros.svh"

module ste_checker import ste_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [ValW-1:0] out_taken_value_o,
  input logic            out_found_o
);

  `STE_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  `STE_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_taken_value_o) && $stable(out_found_o), "stalled result changed")
  `STE_ASSERT_IMP(a_miss_zero, out_valid_o && !out_found_o, out_taken_value_o == '0, "miss with nonzero value")
  `STE_ASSERT_IMP(a_hit_nonzero, out_valid_o && out_found_o, out_taken_value_o != '0, "successor cannot be zero")

endmodule

bind successor_take_engine_unit ste_checker u_ste_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_taken_value_o(out_taken_value_o),
  .out_found_o      (out_found_o)
);
